>>> rtl/rlsr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the ring link node.
package rlsr_pkg;

    localparam int RLSR_RAM_WORDS   = 2048;
    localparam int RLSR_FRAME_BYTES = 513;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [2:0] {
        REQ_REG_RD  = 3'd0,
        REQ_REG_WR  = 3'd1,
        REQ_RAM_RD  = 3'd2,
        REQ_RAM_WR  = 3'd3,
        REQ_RX_BYTE = 3'd4,
        REQ_TX_TICK = 3'd5
    } req_type_t;

    typedef enum logic [1:0] {
        MODE_RECV = 2'd0,
        MODE_XMIT = 2'd1,
        MODE_SENT = 2'd2
    } send_mode_t;

    typedef enum logic [2:0] {
        BK_IMM   = 3'd0,
        BK_READ  = 3'd1,
        BK_MASKW = 3'd2,
        BK_FILLW = 3'd3,
        BK_TXRD  = 3'd4
    } back_op_t;

    // register offsets
    localparam logic [10:0] REG_MODE = 11'd0;
    localparam logic [10:0] REG_CTRL = 11'd1;

    localparam logic [31:0] STATUS_BASE  = 32'h08;
    localparam logic [7:0]  CTRL_RXCLR_A = 8'h14;
    localparam logic [7:0]  CTRL_RXCLR_B = 8'h1C;
    localparam logic [7:0]  CTRL_XMIT_A  = 8'h36;
    localparam logic [7:0]  CTRL_XMIT_B  = 8'h3E;
    localparam logic [7:0]  CTRL_RECV_A  = 8'h37;
    localparam logic [7:0]  CTRL_RECV_B  = 8'h3F;
    localparam logic [7:0]  MAX_SENDER   = 8'h0E;

    localparam logic [10:0] SLOT_SHORT = 11'h100;
    localparam logic [10:0] SLOT_LONG  = 11'h200;

    typedef struct packed {
        back_op_t    op;
        logic [10:0] addr;
        logic [31:0] data;
        logic [31:0] mask;
        logic [1:0]  byte_sel;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        irq_level;
    } q_entry_t;

    function automatic logic [10:0] slot_len(input logic [3:0] id);
        return id[3] ? SLOT_LONG : SLOT_SHORT;
    endfunction

    // word index of byte d in sender id's slot; d stays below 0x200
    function automatic logic [10:0] slot_word(input logic [3:0] id, input logic [10:0] d);
        return {2'b00, id[2:0], 6'b000000} + {2'b00, d[10:2]};
    endfunction

endpackage

>>> rtl/rlsr_ifs.sv
`timescale 1ns / 1ps
// Request and response channel interfaces.
interface rlsr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [10:0] bus_address;
    logic [31:0] bus_wdata;
    logic [31:0] write_mask;
    logic [7:0]  rx_byte;

    modport source (output valid, req_type, bus_address, bus_wdata, write_mask, rx_byte,
                    input ready);
    modport sink   (input valid, req_type, bus_address, bus_wdata, write_mask, rx_byte,
                    output ready);
endinterface

interface rlsr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_level;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;

    modport source (output valid, read_data, irq_level, tx_valid, tx_byte, tx_last,
                    input ready);
    modport sink   (input valid, read_data, irq_level, tx_valid, tx_byte, tx_last,
                    output ready);
endinterface

>>> rtl/rlsr_front.sv
`timescale 1ns / 1ps
// Front end: register bank, link framing, and RAM op classification.
module rlsr_front #(
    parameter int RAM_WORDS   = rlsr_pkg::RLSR_RAM_WORDS,
    parameter int FRAME_BYTES = rlsr_pkg::RLSR_FRAME_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    rlsr_req_if.sink           req,
    input  logic               clearing,
    input  logic               q_space,
    output logic               push,
    output rlsr_pkg::q_entry_t push_entry
);
    import rlsr_pkg::*;

    localparam int PW = $clog2(FRAME_BYTES);
    localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);
    localparam logic [12:0]   WORDS13  = 13'(RAM_WORDS);

    logic [3:0]    node_id_reg, node_id_next;
    logic          link_on_reg, link_on_next;
    send_mode_t    send_mode_reg, send_mode_next;
    logic          rx_status_reg, rx_status_next;
    logic          irq_reg, irq_next;
    logic [PW-1:0] rx_pos_reg, rx_pos_next;
    logic [4:0]    rx_sender_reg, rx_sender_next;
    logic [23:0]   rx_word_reg, rx_word_next;
    logic [PW-1:0] tx_pos_reg, tx_pos_next;

    logic [7:0]    v;
    logic [10:0]   addr_mod;
    logic [10:0]   d_rx, d_tx;
    logic          accept;
    q_entry_t      e;

    assign req.ready  = !clearing && q_space;
    assign push       = req.valid && req.ready;
    assign push_entry = e;

    always_comb
    begin
        node_id_next   = node_id_reg;
        link_on_next   = link_on_reg;
        send_mode_next = send_mode_reg;
        rx_status_next = rx_status_reg;
        irq_next       = irq_reg;
        rx_pos_next    = rx_pos_reg;
        rx_sender_next = rx_sender_reg;
        rx_word_next   = rx_word_reg;
        tx_pos_next    = tx_pos_reg;
        accept         = 1'b0;
        e              = '0;
        e.op           = BK_IMM;

        v = req.bus_wdata[7:0];
        // word address modulo RAM size; one subtract covers the whole bus range
        if (13'(req.bus_address) >= WORDS13)
            addr_mod = 11'(13'(req.bus_address) - WORDS13);
        else
            addr_mod = req.bus_address;
        d_rx = 11'(rx_pos_reg) - 11'd1;
        d_tx = 11'(tx_pos_reg) - 11'd1;

        unique case (req_type_t'(req.req_type))
            REQ_REG_RD:
            begin
                if (req.bus_address == REG_MODE)
                    e.data = STATUS_BASE | (32'(rx_status_reg) << 5);
            end
            REQ_REG_WR:
            begin
                if (req.bus_address == REG_MODE)
                begin
                    if (v[7:4] == 4'h0 || v[7:4] == 4'h2)
                        node_id_next = v[3:0];
                end
                else if (req.bus_address == REG_CTRL)
                begin
                    link_on_next = (v != 8'h00);
                    unique case (v) inside
                        CTRL_RXCLR_A, CTRL_RXCLR_B:
                            rx_status_next = 1'b0;
                        CTRL_XMIT_A, CTRL_XMIT_B:
                        begin
                            send_mode_next = MODE_XMIT;
                            tx_pos_next    = '0;
                        end
                        CTRL_RECV_A, CTRL_RECV_B:
                        begin
                            rx_status_next = 1'b1;
                            send_mode_next = MODE_RECV;
                            rx_pos_next    = '0;
                            rx_sender_next = '0;
                            rx_word_next   = '0;
                        end
                        default: ;
                    endcase
                    if (v[5])
                        irq_next = 1'b1;
                    if (!v[0])
                        irq_next = 1'b0;
                end
            end
            REQ_RAM_RD:
            begin
                e.op   = BK_READ;
                e.addr = addr_mod;
            end
            REQ_RAM_WR:
            begin
                e.op   = BK_MASKW;
                e.addr = addr_mod;
                e.data = req.bus_wdata;
                e.mask = req.write_mask;
            end
            REQ_RX_BYTE:
            begin
                if (link_on_reg && send_mode_reg == MODE_RECV)
                begin
                    if (rx_pos_reg == '0)
                    begin
                        // header beat: sender id
                        accept = (req.rx_byte <= MAX_SENDER)
                              && (req.rx_byte[3:0] != node_id_reg);
                        rx_sender_next = accept ? {1'b1, req.rx_byte[3:0]} : 5'd0;
                        rx_word_next   = '0;
                    end
                    else
                    begin
                        accept = rx_sender_reg[4];
                        if (accept && d_rx < slot_len(rx_sender_reg[3:0]))
                        begin
                            if (d_rx[1:0] == 2'd3)
                            begin
                                e.op         = BK_FILLW;
                                e.addr       = slot_word(rx_sender_reg[3:0], d_rx);
                                e.data       = {rx_word_reg, req.rx_byte};
                                rx_word_next = '0;
                            end
                            else
                                rx_word_next = {rx_word_reg[15:0], req.rx_byte};
                        end
                    end
                    if (accept)
                    begin
                        e.tx_valid = 1'b1;
                        e.tx_byte  = req.rx_byte;
                        e.tx_last  = (rx_pos_reg == LAST_POS);
                    end
                    rx_pos_next = (rx_pos_reg == LAST_POS) ? '0 : rx_pos_reg + 1'b1;
                end
            end
            REQ_TX_TICK:
            begin
                if (link_on_reg && send_mode_reg == MODE_XMIT)
                begin
                    e.tx_valid = 1'b1;
                    if (tx_pos_reg == '0)
                        e.tx_byte = {4'h0, node_id_reg};
                    else if (d_tx < slot_len(node_id_reg))
                    begin
                        e.op       = BK_TXRD;
                        e.addr     = slot_word(node_id_reg, d_tx);
                        e.byte_sel = d_tx[1:0];
                    end
                    if (tx_pos_reg == LAST_POS)
                    begin
                        e.tx_last      = 1'b1;
                        tx_pos_next    = '0;
                        send_mode_next = MODE_SENT;
                    end
                    else
                        tx_pos_next = tx_pos_reg + 1'b1;
                end
            end
            default: ;
        endcase

        e.irq_level = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg   <= '0;
            link_on_reg   <= 1'b0;
            send_mode_reg <= MODE_RECV;
            rx_status_reg <= 1'b0;
            irq_reg       <= 1'b0;
            rx_pos_reg    <= '0;
            rx_sender_reg <= '0;
            rx_word_reg   <= '0;
            tx_pos_reg    <= '0;
        end
        else if (push)
        begin
            node_id_reg   <= node_id_next;
            link_on_reg   <= link_on_next;
            send_mode_reg <= send_mode_next;
            rx_status_reg <= rx_status_next;
            irq_reg       <= irq_next;
            rx_pos_reg    <= rx_pos_next;
            rx_sender_reg <= rx_sender_next;
            rx_word_reg   <= rx_word_next;
            tx_pos_reg    <= tx_pos_next;
        end
    end

endmodule

>>> rtl/rlsr_queue.sv
`timescale 1ns / 1ps
// Small FIFO of classified ops between front and back.
module rlsr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rlsr_pkg::q_entry_t push_entry,
    output logic               space,
    output logic               pop_valid,
    output rlsr_pkg::q_entry_t pop_entry,
    input  logic               pop
);
    import rlsr_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);

    q_entry_t       slots_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]   count_reg, count_next;

    assign space     = (count_reg != (QPW + 1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/rlsr_back.sv
`timescale 1ns / 1ps
// Back end: shared RAM, read/modify/write pipeline, output register, clear sweep.
module rlsr_back #(
    parameter int RAM_WORDS = rlsr_pkg::RLSR_RAM_WORDS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  rlsr_pkg::q_entry_t q_entry,
    output logic               q_pop,
    output logic               clearing,
    rlsr_rsp_if.source         rsp
);
    import rlsr_pkg::*;

    localparam int AW = $clog2(RAM_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(RAM_WORDS - 1);

    logic [31:0]   mem [RAM_WORDS];

    logic          clearing_reg;
    logic [AW-1:0] clr_idx_reg;

    logic          b_valid_reg;
    q_entry_t      b_entry_reg;
    logic [31:0]   rd_reg;
    logic          fwd_reg;
    logic [31:0]   fwd_data_reg;

    logic          out_valid_reg;
    logic [31:0]   read_data_reg;
    logic          irq_level_reg;
    logic          tx_valid_reg;
    logic [7:0]    tx_byte_reg;
    logic          tx_last_reg;

    logic          out_free, b_adv, a_fire, b_fire, b_wr;
    logic [AW-1:0] a_idx, b_idx;
    logic [31:0]   word, b_wdata;
    logic          mem_we;
    logic [AW-1:0] mem_widx;
    logic [31:0]   mem_wdata;
    logic [31:0]   res_data;
    logic [7:0]    res_byte;

    assign clearing = clearing_reg;
    assign out_free = !out_valid_reg || rsp.ready;
    assign b_adv    = !b_valid_reg || out_free;
    assign a_fire   = q_valid && b_adv && !clearing_reg;
    assign q_pop    = a_fire;
    assign b_fire   = b_valid_reg && out_free;

    assign a_idx = AW'(q_entry.addr);
    assign b_idx = AW'(b_entry_reg.addr);

    // a write leaving stage B while stage A reads the same word is forwarded
    assign word = fwd_reg ? fwd_data_reg : rd_reg;

    always_comb
    begin
        b_wr    = b_fire && (b_entry_reg.op == BK_MASKW || b_entry_reg.op == BK_FILLW);
        b_wdata = (b_entry_reg.op == BK_MASKW)
                ? ((word & ~b_entry_reg.mask) | (b_entry_reg.data & b_entry_reg.mask))
                : b_entry_reg.data;

        mem_we    = clearing_reg || b_wr;
        mem_widx  = clearing_reg ? clr_idx_reg : b_idx;
        mem_wdata = clearing_reg ? 32'h0 : b_wdata;

        case (b_entry_reg.op)
            BK_READ: res_data = word;
            BK_IMM:  res_data = b_entry_reg.data;
            default: res_data = 32'h0;
        endcase

        res_byte = b_entry_reg.tx_byte;
        if (b_entry_reg.op == BK_TXRD)
        begin
            case (b_entry_reg.byte_sel)
                2'd0:    res_byte = word[31:24];
                2'd1:    res_byte = word[23:16];
                2'd2:    res_byte = word[15:8];
                default: res_byte = word[7:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_widx] <= mem_wdata;
        if (a_fire)
            rd_reg <= mem[a_idx];
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_entry_reg  <= q_entry;
            fwd_reg      <= b_wr && (b_idx == a_idx);
            fwd_data_reg <= b_wdata;
        end
        if (b_fire)
        begin
            read_data_reg <= res_data;
            irq_level_reg <= b_entry_reg.irq_level;
            tx_valid_reg  <= b_entry_reg.tx_valid;
            tx_byte_reg   <= res_byte;
            tx_last_reg   <= b_entry_reg.tx_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_WORD)
                    clearing_reg <= 1'b0;
            end
            if (a_fire)
                b_valid_reg <= 1'b1;
            else if (b_fire)
                b_valid_reg <= 1'b0;
            if (b_fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = read_data_reg;
    assign rsp.irq_level = irq_level_reg;
    assign rsp.tx_valid  = tx_valid_reg;
    assign rsp.tx_byte   = tx_byte_reg;
    assign rsp.tx_last   = tx_last_reg;

endmodule

>>> rtl/ring_link_shared_ram_node_core.sv
`timescale 1ns / 1ps
// Ring link node top level: front end, op queue, RAM back end.
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  req     | in  | req_type, bus_address, bus_wdata, write_mask, rx_byte
//  rsp     | out | read_data, irq_level, tx_valid, tx_byte, tx_last
//
// One beat per cycle sustained while rsp.ready stays high; a taken req beat passes the queue,
// then the RAM stage (registered read, merge/write on exit), then the output register.
// After reset the RAM is swept to zero, one word a cycle, through all RAM_WORDS words;
// req.ready stays low until the sweep ends.
// A stalled rsp fills the output register, the RAM stage and then the 4-entry queue
// (six beats) before req.ready drops.
module ring_link_shared_ram_node_core #(
    parameter int RAM_WORDS   = rlsr_pkg::RLSR_RAM_WORDS,
    parameter int FRAME_BYTES = rlsr_pkg::RLSR_FRAME_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    rlsr_req_if.sink   req,
    rlsr_rsp_if.source rsp
);
    import rlsr_pkg::*;

    logic     clearing;
    logic     q_space;
    logic     push;
    q_entry_t push_entry;
    logic     pop_valid;
    q_entry_t pop_entry;
    logic     pop;

    rlsr_front #(
        .RAM_WORDS   (RAM_WORDS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .clearing   (clearing),
        .q_space    (q_space),
        .push       (push),
        .push_entry (push_entry)
    );

    rlsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .space      (q_space),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    rlsr_back #(
        .RAM_WORDS (RAM_WORDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (pop_valid),
        .q_entry  (pop_entry),
        .q_pop    (pop),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule
